// File: sv/nfa_prefix_acceptor_macros.svh
// Assertion macros for the NFA prefix acceptor checker.
// Needs signals clk and arst_n in the scope of each use.
`ifndef NFA_PREFIX_ACCEPTOR_MACROS_SVH
`define NFA_PREFIX_ACCEPTOR_MACROS_SVH

// same-cycle implication
`define NPA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// next-cycle implication
`define NPA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`endif

// File: sv/nfa_pkg.sv
// Shared types and constants for the NFA prefix acceptor.
// No dependencies.
`timescale 1ns / 1ps

package nfa_pkg;

	localparam int SYMBOL_FIELD_W = 8;
	localparam int STATE_FIELD_W  = 5;
	localparam int MASK_W         = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// per-cycle control broadcast from the top level to every cell
	typedef struct packed {
		logic clear;    // table clearing pass writes zero rows
		logic load;     // accepted load item with states in range
		logic read;     // accepted step item, read row at symbol
		logic advance;  // stage 1 step moves to the output register
		logic restart;  // restart flag of the step in stage 1
	} nfa_cell_ctrl_t;

endpackage

// File: sv/nfa_prefix_acceptor.sv
// NFA prefix acceptor: one item per cycle unless stalled; a step's result is registered.
// Loads write one table bit at accept and give no result; steps read every cell's row.
// The active-set update (row read, then OR along the cell chain) sets the one-cycle rate.
// Reset: active set {0}, accept_mask 0; input stalls while the table clear zeroes every row.
// Depends on nfa_pkg, nfa_cell, nfa_ram.
`timescale 1ns / 1ps

module nfa_prefix_acceptor
	import nfa_pkg::*;
#(
	parameter int NUM_STATES  = 32,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input item channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [SYMBOL_FIELD_W-1:0] symbol,
	input  logic [STATE_FIELD_W-1:0]  from_state,
	input  logic [STATE_FIELD_W-1:0]  to_state,
	input  logic                      restart,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      accepted,
	// accept_mask write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [MASK_W-1:0]         cfg_data
);

	// Structure: one nfa_cell per state. A cell holds its active bit and a RAM
	// with one successor mask per symbol. On a step all cells read the row for
	// the symbol (stage 1); next cycle each active cell ORs its row into the
	// accumulator it passes to its neighbor, and the chain's end is the new
	// active set, fed back to every cell when stage 1 advances.

	logic [MASK_W-1:0]      accept_mask_q;
	logic                   clr_busy_q;
	logic [SYMBOL_BITS-1:0] clr_cnt_q;

	logic                   step_vld_s1;
	logic                   restart_s1;
	logic                   out_vld_q;
	logic                   accepted_q;

	logic                   in_acc;
	logic                   step_acc;
	logic                   load_ok;
	logic                   advance;
	logic [SYMBOL_BITS-1:0] sym;
	logic [SYMBOL_BITS-1:0] wr_addr;
	logic [NUM_STATES-1:0]  wr_bit;
	logic [NUM_STATES-1:0]  accept_ext;
	logic [NUM_STATES-1:0]  next_set;
	logic [NUM_STATES-1:0]  acc [NUM_STATES+1];
	nfa_cell_ctrl_t         ctrl;

	// Handshake. Stage 1 frees when it moves into the output register, which
	// in turn frees when its result is taken; a stalled result still leaves
	// room for one more step in stage 1.
	assign advance   = step_vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall  = clr_busy_q || (step_vld_s1 && out_vld_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign step_acc  = in_acc && (command == CMD_STEP);

	// loads naming a state at or past NUM_STATES are dropped
	assign load_ok = in_acc && (command == CMD_LOAD)
		&& (int'(from_state) < NUM_STATES) && (int'(to_state) < NUM_STATES);

	assign sym     = symbol[SYMBOL_BITS-1:0];
	assign wr_addr = clr_busy_q ? clr_cnt_q : sym;
	assign wr_bit  = NUM_STATES'(1) << to_state;

	assign ctrl.clear   = clr_busy_q;
	assign ctrl.load    = load_ok;
	assign ctrl.read    = step_acc;
	assign ctrl.advance = advance;
	assign ctrl.restart = restart_s1;

	// accept bits exist for the first MASK_W states only
	for (genvar g = 0; g < NUM_STATES; g++) begin : g_accept
		if (g < MASK_W) begin : g_bit
			assign accept_ext[g] = accept_mask_q[g];
		end else begin : g_none
			assign accept_ext[g] = 1'b0;
		end
	end

	assign acc[0] = '0;

	for (genvar g = 0; g < NUM_STATES; g++) begin : g_cell
		nfa_cell #(
			.NUM_STATES (NUM_STATES),
			.SYMBOL_BITS(SYMBOL_BITS),
			.STATE_ID   (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.from_state(from_state),
			.wr_addr   (wr_addr),
			.wr_bit    (wr_bit),
			.rd_addr   (sym),
			.next_set  (next_set),
			.acc_in    (acc[g]),
			.acc_out   (acc[g+1])
		);
	end

	assign next_set = acc[NUM_STATES];

	// Table clear after reset: one row per cycle in all cells at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == {SYMBOL_BITS{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			accept_mask_q <= cfg_data;
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (step_acc) begin
				step_vld_s1 <= 1'b1;
			end else if (advance) begin
				step_vld_s1 <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (step_acc) begin
			restart_s1 <= restart;
		end
		if (advance) begin
			accepted_q <= |(next_set & accept_ext);
		end
	end

	assign out_valid = out_vld_q;
	assign accepted  = accepted_q;

endmodule

// File: sv/nfa_ram.sv
// Generic single-write, single-read RAM with bit write mask and registered read.
// No dependencies.
`timescale 1ns / 1ps

module nfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wmask,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wmask[i]) begin
					mem_q[waddr][i] <= wdata[i];
				end
			end
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/nfa_cell.sv
// One NFA state: its row of successor masks per symbol and its active bit.
// Depends on nfa_pkg and nfa_ram.
`timescale 1ns / 1ps

module nfa_cell
	import nfa_pkg::*;
#(
	parameter int NUM_STATES  = 32,
	parameter int SYMBOL_BITS = 8,
	parameter int STATE_ID    = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  nfa_cell_ctrl_t           ctrl,
	input  logic [STATE_FIELD_W-1:0] from_state,
	input  logic [SYMBOL_BITS-1:0]   wr_addr,
	input  logic [NUM_STATES-1:0]    wr_bit,
	input  logic [SYMBOL_BITS-1:0]   rd_addr,
	input  logic [NUM_STATES-1:0]    next_set,
	input  logic [NUM_STATES-1:0]    acc_in,
	output logic [NUM_STATES-1:0]    acc_out
);

	localparam int DEPTH = 1 << SYMBOL_BITS;
	localparam logic RESET_ACTIVE = (STATE_ID == 0);

	logic                  active_q;
	logic                  active_eff;
	logic                  we;
	logic [NUM_STATES-1:0] wmask;
	logic [NUM_STATES-1:0] wdata;
	logic [NUM_STATES-1:0] row;

	assign we    = ctrl.clear || (ctrl.load && (int'(from_state) == STATE_ID));
	assign wmask = ctrl.clear ? {NUM_STATES{1'b1}} : wr_bit;
	assign wdata = {NUM_STATES{~ctrl.clear}};

	nfa_ram #(
		.WIDTH(NUM_STATES),
		.DEPTH(DEPTH)
	) u_row (
		.clk  (clk),
		.we   (we),
		.waddr(wr_addr),
		.wmask(wmask),
		.wdata(wdata),
		.re   (ctrl.read),
		.raddr(rd_addr),
		.rdata(row)
	);

	// restart makes state 0 the only active one before the step
	assign active_eff = ctrl.restart ? RESET_ACTIVE : active_q;
	assign acc_out    = acc_in | (active_eff ? row : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= RESET_ACTIVE;
		end else if (ctrl.advance) begin
			active_q <= next_set[STATE_ID];
		end
	end

endmodule

// File: sv/nfa_prefix_acceptor_chk.sv
// Port-level checker for nfa_prefix_acceptor, bound to the top level.
// Depends on nfa_pkg and nfa_prefix_acceptor_macros.svh.
`timescale 1ns / 1ps
`include "nfa_prefix_acceptor_macros.svh"

module nfa_prefix_acceptor_chk
	import nfa_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      command,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      accepted,
	input logic                      cfg_valid,
	input logic                      cfg_ready
);

	// a held result keeps its value
	`NPA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(accepted))

	// a fresh result comes from an accepted step that passed through stage 1 into the output register
	`NPA_ASSERT_IMP(a_out_from_step, $rose(out_valid),
		$past(in_valid && !in_stall && (command == CMD_STEP), 2))

	// with output stalled and one step already queued behind it, input must stall
	`NPA_ASSERT_IMP(a_full_stall,
		out_valid && out_stall
		&& $past(out_valid && out_stall && in_valid && !in_stall && (command == CMD_STEP)),
		in_stall)

	// the mask register never refuses a write
	`NPA_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind nfa_prefix_acceptor nfa_prefix_acceptor_chk u_chk (.*);

// File: dv/tb_nfa_prefix_acceptor.sv
// Self-checking testbench for nfa_prefix_acceptor: directed and random load/step items,
// checked against an in-bench predictor of the transition table and active set.
// Depends on nfa_pkg and the nfa_prefix_acceptor RTL.
`timescale 1ns / 1ps

module tb_nfa_prefix_acceptor;
	import nfa_pkg::*;

	localparam int N_ST       = 32;
	localparam int SYM_BITS   = 8;
	localparam int SETTLE_CYC = 8;       // lets trailing load writes land
	localparam int HOLD_CYC   = 300;     // long result-side hold-off
	localparam int CYCLE_CAP  = 500000;
	localparam int PHASE_ITEMS = 228;
	localparam logic [MASK_W-1:0] STATE_OK =
		(N_ST >= MASK_W) ? '1 : ((MASK_W'(1) << N_ST) - 1);

	typedef struct packed {
		logic                      command;
		logic [SYMBOL_FIELD_W-1:0] symbol;
		logic [STATE_FIELD_W-1:0]  from_state;
		logic [STATE_FIELD_W-1:0]  to_state;
		logic                      restart;
	} nfa_item_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      command = CMD_LOAD;
	logic [SYMBOL_FIELD_W-1:0] symbol = '0;
	logic [STATE_FIELD_W-1:0]  from_state = '0;
	logic [STATE_FIELD_W-1:0]  to_state = '0;
	logic                      restart = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      accepted;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [MASK_W-1:0]         cfg_data = '0;

	// predictor state: successor masks per (state, symbol), active set, accepting mask
	logic [MASK_W-1:0] succ_tab [MASK_W][256];
	logic [MASK_W-1:0] live_set;
	logic [MASK_W-1:0] accept_bits;

	nfa_item_t   item_q[$];          // items waiting for the driver
	logic        accept_flag_q[$];   // expected accepted flags, oldest first
	int unsigned items_queued = 0;
	int unsigned items_taken  = 0;
	int unsigned err_cnt      = 0;
	int unsigned cycle_cnt    = 0;

	// idling controls; the enables and press_req are written by the sequence only
	logic        tx_idle_on = 1'b1;
	logic        rx_idle_on = 1'b1;
	int unsigned press_req  = 0;
	int unsigned press_seen = 0;
	int unsigned hold_left  = 0;
	int unsigned tx_wait    = 0;
	int unsigned rx_wait    = 0;

	nfa_prefix_acceptor #(
		.NUM_STATES (N_ST),
		.SYMBOL_BITS(SYM_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.symbol    (symbol),
		.from_state(from_state),
		.to_state  (to_state),
		.restart   (restart),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accepted  (accepted),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one accepted item to the predicted table and active set.
	// A load ORs one target bit into its entry; a step, after any restart to {0},
	// replaces the active set by the union of successors and queues the expected flag.
	function automatic void nfa_track(input nfa_item_t it);
		logic [MASK_W-1:0] succ;
		int unsigned       sym;
		sym = it.symbol & ((1 << SYM_BITS) - 1);
		if (it.command == CMD_LOAD) begin
			// restart is a don't-care on loads
			if (it.from_state < N_ST && it.to_state < N_ST)
				succ_tab[it.from_state][sym][it.to_state] = 1'b1;
		end else begin
			if (it.restart)
				live_set = MASK_W'(1);
			succ = '0;
			for (int s = 0; s < MASK_W; s++)
				if (live_set[s])
					succ |= succ_tab[s][sym];
			// an empty set stays empty until the next restart
			live_set = succ & STATE_OK;
			accept_flag_q.push_back(|(live_set & accept_bits & STATE_OK));
		end
	endfunction

	// Input driver: presents queued items, holds them while stalled, and
	// draws a fresh gap after each accepted item.
	always @(posedge clk) begin : drv
		nfa_item_t   nxt;
		nfa_item_t   on_pins;
		int unsigned gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait  <= 0;
		end else begin
			gap = tx_wait;
			if (in_valid && !in_stall) begin
				on_pins = '{command, symbol, from_state, to_state, restart};
				nfa_track(on_pins);
				items_taken++;
				gap = (tx_idle_on && $urandom_range(0, 1)) ? $urandom_range(0, 17) : 0;
			end
			if (in_valid && in_stall) begin
				// stalled: payload held as is
			end else if (gap != 0) begin
				gap--;
				in_valid <= 1'b0;
			end else if (item_q.size() != 0) begin
				nxt = item_q.pop_front();
				command    <= nxt.command;
				symbol     <= nxt.symbol;
				from_state <= nxt.from_state;
				to_state   <= nxt.to_state;
				restart    <= nxt.restart;
				in_valid   <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
			tx_wait <= gap;
		end
	end

	// Long hold-off on the result side, started once per request
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (press_seen != press_req) begin
			press_seen <= press_req;
			hold_left  <= HOLD_CYC;
		end
	end

	// Result monitor: compares each accepted result with the oldest expectation
	always @(posedge clk) begin : mon
		logic        want;
		int unsigned w;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait   <= 0;
		end else begin
			w = rx_wait;
			if (out_valid && !out_stall) begin
				if (accept_flag_q.size() == 0) begin
					$error("accepted: result %0b with nothing expected", accepted);
					err_cnt++;
				end else begin
					want = accept_flag_q.pop_front();
					if (accepted !== want) begin
						$error("accepted: expected %0b, got %0b", want, accepted);
						err_cnt++;
					end
				end
				w = (rx_idle_on && $urandom_range(0, 1)) ? $urandom_range(0, 17) : 0;
			end else if (w != 0) begin
				w--;
			end
			rx_wait   <= w;
			out_stall <= (w != 0) || (hold_left != 0);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic add_load(input logic [STATE_FIELD_W-1:0] fr, input logic [7:0] sym,
			input logic [STATE_FIELD_W-1:0] to, input logic rst);
		item_q.push_back('{CMD_LOAD, sym, fr, to, rst});
		items_queued++;
	endtask

	task automatic add_step(input logic [7:0] sym, input logic rst);
		item_q.push_back('{CMD_STEP, sym, STATE_FIELD_W'($urandom), STATE_FIELD_W'($urandom), rst});
		items_queued++;
	endtask

	// Wait until every item is taken and every result is back, then let
	// trailing load writes land.
	task automatic drain_block();
		do @(posedge clk);
		while (items_taken != items_queued || accept_flag_q.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Only called while the block is idle
	task automatic write_accept_mask(input logic [MASK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid   <= 1'b0;
		accept_bits = val;
	endtask

	// One random phase: rounds of a few loads over a small alphabet and
	// state pool, then a word that mostly opens with a restart. Some noise
	// items and broken words are mixed in.
	task automatic queue_phase(input int unsigned n);
		logic [7:0]               alpha [6];
		logic [STATE_FIELD_W-1:0] pool [10];
		int unsigned n_alpha;
		int unsigned n_pool;
		int unsigned made;
		int unsigned len;
		nfa_item_t   junk;
		n_alpha = $urandom_range(2, 6);
		n_pool  = $urandom_range(3, 10);
		foreach (alpha[i]) alpha[i] = 8'($urandom);
		foreach (pool[i]) pool[i] = STATE_FIELD_W'($urandom);
		pool[0] = '0;  // start state always reachable
		made = 0;
		while (made < n) begin
			repeat ($urandom_range(0, 3)) begin
				add_load(pool[$urandom_range(0, n_pool - 1)], alpha[$urandom_range(0, n_alpha - 1)],
					pool[$urandom_range(0, n_pool - 1)], 1'($urandom));
				made++;
			end
			if ($urandom_range(0, 9) == 0) begin
				junk = nfa_item_t'($urandom);
				item_q.push_back(junk);
				items_queued++;
				made++;
			end
			len = $urandom_range(1, 12);
			add_step(alpha[$urandom_range(0, n_alpha - 1)], $urandom_range(0, 7) != 0);
			repeat (len - 1)
				add_step(($urandom_range(0, 9) == 0) ? 8'($urandom)
					: alpha[$urandom_range(0, n_alpha - 1)], $urandom_range(0, 19) == 0);
			made += len;
		end
	endtask

	initial begin
		logic [MASK_W-1:0] mask;
		foreach (succ_tab[i, j]) succ_tab[i][j] = '0;
		live_set    = MASK_W'(1);
		accept_bits = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first and last state and symbol, duplicates, empty set
		write_accept_mask(32'h8000_0001);
		add_step(8'h00, 1'b0);             // empty table, no restart
		add_step(8'hFF, 1'b1);             // restart into empty table
		add_load(5'd0, 8'h00, 5'd31, 1'b0);
		add_load(5'd31, 8'hFF, 5'd0, 1'b1);   // restart ignored on a load
		add_load(5'd31, 8'hFF, 5'd31, 1'b0);
		add_load(5'd0, 8'h00, 5'd31, 1'b0);   // duplicate transition
		add_load(5'h15, 8'hAA, 5'h0A, 1'b0);
		add_load(5'h0A, 8'h55, 5'h15, 1'b1);
		add_load(5'd0, 8'hAA, 5'h15, 1'b0);
		add_step(8'h00, 1'b1);
		add_step(8'hFF, 1'b0);
		add_step(8'hFF, 1'b0);
		add_step(8'h00, 1'b0);
		add_step(8'h5A, 1'b0);             // active set dies
		add_step(8'hFF, 1'b0);             // stays empty
		add_step(8'hAA, 1'b1);
		add_step(8'hAA, 1'b0);
		add_step(8'h55, 1'b0);
		add_step(8'h00, 1'b1);
		drain_block();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: mask = '1;
				1: mask = '0;
				3: mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
				5: mask = 32'h0000_0001;
				default: mask = $urandom;
			endcase
			write_accept_mask(mask);
			tx_idle_on <= (ph % 3) != 2;
			rx_idle_on <= (ph % 4) != 3 && ph != 5;
			queue_phase(PHASE_ITEMS);
			// steady offer from the sender while results are held back
			if (ph == 2 || ph == 5)
				press_req <= press_req + 1;
			drain_block();
		end

		if (err_cnt == 0 && accept_flag_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
